[design/string_pair_predicate_top_macros.svh]
// ---------------------------------------------------------------------------
// String pair predicate assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef STRING_PAIR_PREDICATE_TOP_MACROS_SVH
`define STRING_PAIR_PREDICATE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SPP_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("string_pair_predicate: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SPP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("string_pair_predicate: next-cycle check failed");

`endif

[design/spp_pkg.sv]
// ---------------------------------------------------------------------------
// String pair predicate package
// Item types, compare modes, register indexes and the case fold helper.
// ---------------------------------------------------------------------------
package spp_pkg;

  typedef struct packed {
    logic       which_string;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_of_string;
    logic       term_found;
  } in_item_t;

  typedef struct packed {
    logic       outcome;
    logic [8:0] distance;
    logic       overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_CONTAIN = 2'd0,
    MODE_EQUAL   = 2'd1,
    MODE_EDIT    = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_e;

  localparam logic REG_COMPARE_MODE   = 1'b0;
  localparam logic REG_DISTANCE_LIMIT = 1'b1;

  localparam logic [1:0]  COMPARE_MODE_RST = 2'd1;
  localparam logic [15:0] DIST_SAT         = 16'd511;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

[design/spp_ram.sv]
// ---------------------------------------------------------------------------
// String pair predicate RAM
// One write port and one registered read port.
// ---------------------------------------------------------------------------
module spp_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/spp_engine.sv]
// ---------------------------------------------------------------------------
// String pair predicate engine
// Sequencer that walks the stored strings with one shared byte compare and
// one min-of-three cell, for equality, containment and edit distance.
// ---------------------------------------------------------------------------
module spp_engine #(
  parameter int unsigned LW = 9,
  parameter int unsigned AW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   go_i,
  input  logic [1:0]             mode_i,
  input  logic [15:0]            limit_i,
  input  logic [LW-1:0]          len1_i,
  input  logic [LW-1:0]          len2_i,
  output logic [AW-1:0]          addr_a_o,
  input  logic [7:0]             data_a_i,
  output logic [AW-1:0]          addr_b_o,
  input  logic [7:0]             data_b_i,
  output logic [LW-1:0]          row_raddr_o,
  input  logic [LW-1:0]          row_rdata_i,
  output logic                   row_we_o,
  output logic [LW-1:0]          row_waddr_o,
  output logic [LW-1:0]          row_wdata_o,
  output logic                   fin_o,
  output spp_pkg::out_item_t     res_o
);
  import spp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_EQ_RD   = 10'b00_0000_0010,
    S_EQ_CMP  = 10'b00_0000_0100,
    S_CT_RD   = 10'b00_0000_1000,
    S_CT_CMP  = 10'b00_0001_0000,
    S_ED_INIT = 10'b00_0010_0000,
    S_ED_ROW  = 10'b00_0100_0000,
    S_ED_ROWA = 10'b00_1000_0000,
    S_ED_RD   = 10'b01_0000_0000,
    S_ED_CMP  = 10'b10_0000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] len1_q, len1_d, len2_q, len2_d;
  logic [LW-1:0] pos_q, pos_d;   // shift s or row i
  logic [LW-1:0] idx_q, idx_d;   // offset k or column j
  logic [7:0]    a_q, a_d;
  logic [LW-1:0] diag_q, diag_d, left_q, left_d;
  logic          fin_q, fin_d;
  out_item_t     res_q, res_d;

  // shared compare unit
  logic [7:0]    cmp_x, cmp_y;
  logic          cmp_eq;
  logic [LW:0]   c_up, c_left, c_sub, best;
  logic [LW-1:0] sum_sk;
  logic          finish, fin_val, fin_edit;
  logic [LW-1:0] fin_dist;
  logic [15:0]   dist_ext;

  assign cmp_eq = (cmp_x == cmp_y);
  assign sum_sk = pos_q + idx_q;

  always_comb begin
    state_d     = state_q;
    len1_d      = len1_q;
    len2_d      = len2_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    a_d         = a_q;
    diag_d      = diag_q;
    left_d      = left_q;
    addr_a_o    = '0;
    addr_b_o    = '0;
    row_raddr_o = '0;
    row_we_o    = 1'b0;
    row_waddr_o = '0;
    row_wdata_o = '0;
    cmp_x       = data_a_i;
    cmp_y       = data_b_i;
    c_up        = {1'b0, row_rdata_i} + 1'b1;
    c_left      = {1'b0, left_q} + 1'b1;
    c_sub       = '0;
    best        = '0;
    finish      = 1'b0;
    fin_val     = 1'b0;
    fin_edit    = 1'b0;
    fin_dist    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          len1_d = len1_i;
          len2_d = len2_i;
          pos_d  = '0;
          idx_d  = '0;
          unique case (mode_i)
            MODE_EQUAL: begin
              if (len1_i != len2_i) begin
                finish = 1'b1;
              end else if (len1_i == '0) begin
                finish  = 1'b1;
                fin_val = 1'b1;
              end else begin
                state_d = S_EQ_RD;
              end
            end
            MODE_CONTAIN: begin
              if (len1_i == '0) begin
                finish  = 1'b1;
                fin_val = 1'b1;
              end else if (len1_i > len2_i) begin
                finish = 1'b1;
              end else begin
                state_d = S_CT_RD;
              end
            end
            MODE_EDIT: state_d = S_ED_INIT;
            default:   finish  = 1'b1;
          endcase
        end
      end
      S_EQ_RD: begin
        addr_a_o = idx_q[AW-1:0];
        addr_b_o = idx_q[AW-1:0];
        state_d  = S_EQ_CMP;
      end
      S_EQ_CMP: begin
        if (!cmp_eq) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else if (idx_q + 1'b1 == len1_q) begin
          finish  = 1'b1;
          fin_val = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_EQ_RD;
        end
      end
      S_CT_RD: begin
        addr_a_o = idx_q[AW-1:0];
        addr_b_o = sum_sk[AW-1:0];
        state_d  = S_CT_CMP;
      end
      S_CT_CMP: begin
        if (cmp_eq) begin
          if (idx_q + 1'b1 == len1_q) begin
            finish  = 1'b1;
            fin_val = 1'b1;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_CT_RD;
          end
        end else if (pos_q + len1_q == len2_q) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          pos_d   = pos_q + 1'b1;
          idx_d   = '0;
          state_d = S_CT_RD;
        end
      end
      S_ED_INIT: begin
        row_we_o    = 1'b1;
        row_waddr_o = idx_q;
        row_wdata_o = idx_q;
        if (idx_q == len2_q) begin
          if (len1_q == '0) begin
            finish   = 1'b1;
            fin_edit = 1'b1;
            fin_dist = len2_q;
            state_d  = S_IDLE;
          end else begin
            pos_d   = LW'(1);
            state_d = S_ED_ROW;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_ED_ROW: begin
        addr_a_o    = AW'(pos_q - 1'b1);
        row_raddr_o = '0;
        state_d     = S_ED_ROWA;
      end
      S_ED_ROWA: begin
        a_d         = fold_upper(data_a_i);
        diag_d      = row_rdata_i;
        left_d      = pos_q;
        row_we_o    = 1'b1;
        row_waddr_o = '0;
        row_wdata_o = pos_q;
        idx_d       = LW'(1);
        if (len2_q != '0) begin
          state_d = S_ED_RD;
        end else if (pos_q == len1_q) begin
          finish   = 1'b1;
          fin_edit = 1'b1;
          fin_dist = pos_q;
          state_d  = S_IDLE;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = S_ED_ROW;
        end
      end
      S_ED_RD: begin
        addr_b_o    = AW'(idx_q - 1'b1);
        row_raddr_o = idx_q;
        state_d     = S_ED_CMP;
      end
      S_ED_CMP: begin
        cmp_x = a_q;
        cmp_y = fold_upper(data_b_i);
        c_sub = {1'b0, diag_q} + {{LW{1'b0}}, !cmp_eq};
        best  = c_up;
        if (c_left < best) begin
          best = c_left;
        end
        if (c_sub < best) begin
          best = c_sub;
        end
        row_we_o    = 1'b1;
        row_waddr_o = idx_q;
        row_wdata_o = best[LW-1:0];
        diag_d      = row_rdata_i;
        left_d      = best[LW-1:0];
        if (idx_q == len2_q) begin
          if (pos_q == len1_q) begin
            finish   = 1'b1;
            fin_edit = 1'b1;
            fin_dist = best[LW-1:0];
            state_d  = S_IDLE;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = S_ED_ROW;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_ED_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign dist_ext = 16'(fin_dist);

  always_comb begin
    fin_d          = finish;
    res_d          = res_q;
    res_d.overflow = 1'b0;
    if (finish) begin
      if (fin_edit) begin
        res_d.outcome  = (dist_ext <= limit_i);
        res_d.distance = (dist_ext > DIST_SAT) ? DIST_SAT[8:0] : dist_ext[8:0];
      end else begin
        res_d.outcome  = fin_val;
        res_d.distance = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len1_q <= len1_d;
    len2_q <= len2_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    a_q    <= a_d;
    diag_q <= diag_d;
    left_q <= left_d;
    res_q  <= res_d;
  end

  assign fin_o = fin_q;
  assign res_o = res_q;

endmodule

[design/string_pair_predicate_top.sv]
// ---------------------------------------------------------------------------
// String pair predicate
// Buffers two byte strings and tests containment, equality or case-folded
// edit distance within a limit, giving one result per string pair.
// ---------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------
//  input     | start_i, busy_o      | in_i  (spp_pkg::in_item_t)
//  result    | done_o (one cycle)   | res_o (spp_pkg::out_item_t)
//  config    | cfg_we_i, cfg_idx_i  | cfg_wdata_i
//
// Items that do not close the second string are accepted while busy_o is low.
// A closing item that starts the engine raises busy_o while the engine walks the
// buffers, each step a memory read followed by a compare, for equality, containment
// or edit distance.
// A pair with a missing term, an overflow or an unknown mode answers false without the engine.
// Reset clears control state only; no memory clearing pass. done_o cannot stall.
module string_pair_predicate_top #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  spp_pkg::in_item_t  in_i,
  output logic               done_o,
  output spp_pkg::out_item_t res_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import spp_pkg::*;
  `include "string_pair_predicate_top_macros.svh"

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [1:0]    mode_q;
  logic [15:0]   limit_q;
  logic [LW-1:0] len1_q, len1_d, len2_q, len2_d;
  logic          first_done_q, first_done_d;
  logic          missing_q, missing_d;
  logic          ovf_q, ovf_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  out_item_t     res_q, res_d;

  logic          accept;
  logic          we_a, we_b, eng_go;
  logic [AW-1:0] eng_addr_a, eng_addr_b;
  logic [7:0]    data_a, data_b;
  logic [LW-1:0] row_raddr, row_rdata, row_waddr, row_wdata;
  logic          row_we, eng_fin;
  out_item_t     eng_res;
  logic          miss_n, ovf_n;

  assign accept = start_i && !busy_q;

  always_comb begin
    len1_d       = len1_q;
    len2_d       = len2_q;
    first_done_d = first_done_q;
    missing_d    = missing_q;
    ovf_d        = ovf_q;
    busy_d       = busy_q;
    done_d       = 1'b0;
    res_d        = res_q;
    we_a         = 1'b0;
    we_b         = 1'b0;
    eng_go       = 1'b0;
    miss_n       = missing_q || !in_i.term_found;
    ovf_n        = ovf_q;
    if (eng_fin) begin
      busy_d = 1'b0;
      done_d = 1'b1;
      res_d  = eng_res;
    end
    if (accept) begin
      missing_d = miss_n;
      if (!in_i.which_string) begin
        if (!first_done_q) begin
          if (in_i.has_byte) begin
            if (len1_q < LW'(MAX_LEN)) begin
              we_a   = 1'b1;
              len1_d = len1_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_i.end_of_string) begin
            first_done_d = 1'b1;
          end
        end
      end else begin
        if (in_i.has_byte) begin
          if (len2_q < LW'(MAX_LEN)) begin
            we_b   = 1'b1;
            len2_d = len2_q + 1'b1;
          end else begin
            ovf_n = 1'b1;
            ovf_d = 1'b1;
          end
        end
        if (in_i.end_of_string) begin
          // close the pair: run the engine or answer false at once
          if (!miss_n && !ovf_n && (mode_q == MODE_CONTAIN || mode_q == MODE_EQUAL ||
                                    mode_q == MODE_EDIT)) begin
            eng_go = 1'b1;
            busy_d = 1'b1;
          end else begin
            done_d         = 1'b1;
            res_d.outcome  = 1'b0;
            res_d.distance = '0;
            res_d.overflow = ovf_n;
          end
          len1_d       = '0;
          len2_d       = '0;
          first_done_d = 1'b0;
          missing_d    = 1'b0;
          ovf_d        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= COMPARE_MODE_RST;
      limit_q      <= '0;
      len1_q       <= '0;
      len2_q       <= '0;
      first_done_q <= 1'b0;
      missing_q    <= 1'b0;
      ovf_q        <= 1'b0;
      busy_q       <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COMPARE_MODE:   mode_q  <= cfg_wdata_i[1:0];
          REG_DISTANCE_LIMIT: limit_q <= cfg_wdata_i;
          default:            mode_q  <= mode_q;
        endcase
      end
      len1_q       <= len1_d;
      len2_q       <= len2_d;
      first_done_q <= first_done_d;
      missing_q    <= missing_d;
      ovf_q        <= ovf_d;
      busy_q       <= busy_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  spp_ram #(.W(8), .DEPTH(MAX_LEN), .AW(AW)) u_first (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (len1_q[AW-1:0]),
    .wdata_i (in_i.byte_value),
    .raddr_i (eng_addr_a),
    .rdata_o (data_a)
  );

  spp_ram #(.W(8), .DEPTH(MAX_LEN), .AW(AW)) u_second (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (len2_q[AW-1:0]),
    .wdata_i (in_i.byte_value),
    .raddr_i (eng_addr_b),
    .rdata_o (data_b)
  );

  spp_ram #(.W(LW), .DEPTH(MAX_LEN + 1), .AW(LW)) u_row (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  spp_engine #(.LW(LW), .AW(AW)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (eng_go),
    .mode_i      (mode_q),
    .limit_i     (limit_q),
    .len1_i      (len1_q),
    .len2_i      (len2_q + LW'(we_b)),
    .addr_a_o    (eng_addr_a),
    .data_a_i    (data_a),
    .addr_b_o    (eng_addr_b),
    .data_b_i    (data_b),
    .row_raddr_o (row_raddr),
    .row_rdata_i (row_rdata),
    .row_we_o    (row_we),
    .row_waddr_o (row_waddr),
    .row_wdata_o (row_wdata),
    .fin_o       (eng_fin),
    .res_o       (eng_res)
  );

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

  `SPP_ASSERT_NOW(a_done_not_busy, done_o, !busy_o)
  `SPP_ASSERT_NOW(a_fin_while_busy, eng_fin, busy_q)
  `SPP_ASSERT_NEXT(a_go_sets_busy, eng_go, busy_o)
  `SPP_ASSERT_NOW(a_ovf_false, done_o && res_o.overflow, !res_o.outcome)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// String pair predicate testbench
// Streams string pairs into the block under every compare mode and checks
// each result against a behavioral predictor of containment, equality and
// case-folded edit distance.
// ---------------------------------------------------------------------------
module tb_top;
  import spp_pkg::*;

  localparam int unsigned MAX_LEN   = 256;
  localparam int unsigned CYC_LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_item_t    in_i = '0;
  logic        done_o;
  out_item_t   res_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  string_pair_predicate_top #(.MAX_LEN(MAX_LEN)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .in_i(in_i), .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [1:0]  pm_mode;
  logic [15:0] pm_limit;
  logic [7:0]  pm_first [MAX_LEN];
  logic [7:0]  pm_second [MAX_LEN];
  int unsigned pm_len1, pm_len2;
  bit          pm_first_closed, pm_missing, pm_ovf;

  out_item_t   verdict_q [$];
  int          n_errors = 0;
  int unsigned cycles = 0;

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic int unsigned levenshtein();
    int unsigned row [MAX_LEN + 1];
    int unsigned diag, up, best;
    for (int j = 0; j <= pm_len2; j++) row[j] = j;
    for (int i = 1; i <= pm_len1; i++) begin
      diag = row[0];
      row[0] = i;
      for (int j = 1; j <= pm_len2; j++) begin
        up = row[j];
        best = up + 1;
        if (row[j-1] + 1 < best) best = row[j-1] + 1;
        if (diag + (upcase(pm_first[i-1]) == upcase(pm_second[j-1]) ? 0 : 1) < best)
          best = diag + (upcase(pm_first[i-1]) == upcase(pm_second[j-1]) ? 0 : 1);
        diag = up;
        row[j] = best;
      end
    end
    return row[pm_len2];
  endfunction

  function automatic bit contains();
    bit hit;
    if (pm_len1 == 0) return 1'b1;
    if (pm_len1 > pm_len2) return 1'b0;
    for (int s = 0; s + pm_len1 <= pm_len2; s++) begin
      hit = 1'b1;
      for (int k = 0; k < pm_len1; k++)
        if (pm_second[s+k] != pm_first[k]) hit = 1'b0;
      if (hit) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit equal();
    if (pm_len1 != pm_len2) return 1'b0;
    for (int k = 0; k < pm_len1; k++)
      if (pm_first[k] != pm_second[k]) return 1'b0;
    return 1'b1;
  endfunction

  // Returns 1 and fills the verdict when the item closes the second string.
  function automatic bit predict_pair(input in_item_t it, output out_item_t v);
    int unsigned d;
    v = '0;
    if (!it.term_found) pm_missing = 1'b1;
    if (!it.which_string) begin
      if (pm_first_closed) return 1'b0;
      if (it.has_byte) begin
        if (pm_len1 < MAX_LEN) pm_first[pm_len1++] = it.byte_value;
        else pm_ovf = 1'b1;
      end
      if (it.end_of_string) pm_first_closed = 1'b1;
      return 1'b0;
    end
    if (it.has_byte) begin
      if (pm_len2 < MAX_LEN) pm_second[pm_len2++] = it.byte_value;
      else pm_ovf = 1'b1;
    end
    if (!it.end_of_string) return 1'b0;
    if (!pm_missing && !pm_ovf) begin
      case (pm_mode)
        MODE_CONTAIN: v.outcome = contains();
        MODE_EQUAL:   v.outcome = equal();
        MODE_EDIT: begin
          d = levenshtein();
          v.distance = (d > 511) ? 9'd511 : d[8:0];
          v.outcome = (d <= pm_limit);
        end
        default: ;
      endcase
    end
    v.overflow = pm_ovf;
    pm_len1 = 0;
    pm_len2 = 0;
    pm_first_closed = 1'b0;
    pm_missing = 1'b0;
    pm_ovf = 1'b0;
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result %p", res_o);
        n_errors++;
      end else begin
        if (res_o.outcome !== verdict_q[0].outcome) begin
          $error("outcome: expected %0d actual %0d", verdict_q[0].outcome, res_o.outcome);
          n_errors++;
        end
        if (res_o.distance !== verdict_q[0].distance) begin
          $error("distance: expected %0d actual %0d", verdict_q[0].distance,
                 res_o.distance);
          n_errors++;
        end
        if (res_o.overflow !== verdict_q[0].overflow) begin
          $error("overflow: expected %0d actual %0d", verdict_q[0].overflow,
                 res_o.overflow);
          n_errors++;
        end
        void'(verdict_q.pop_front());
      end
    end
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drop start only when a real gap follows; a zero gap keeps items back to back.
  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) begin
      start_i <= 1'b0;
      in_i <= '0;
    end
    repeat (n) @(posedge clk_i);
  endtask

  // Drive one item; returns after it is accepted, with start still high.
  task automatic send_item(input in_item_t it);
    out_item_t v;
    start_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (predict_pair(it, v)) verdict_q.push_back(v);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    in_i <= '0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_COMPARE_MODE) pm_mode = val[1:0];
    else pm_limit = val;
  endtask

  function automatic in_item_t mk(bit w, logic [7:0] b, bit h, bit e, bit f);
    in_item_t it;
    it.which_string = w;
    it.byte_value = b;
    it.has_byte = h;
    it.end_of_string = e;
    it.term_found = f;
    return it;
  endfunction

  function automatic logic [7:0] rand_char(int unsigned alpha);
    case (alpha)
      0: return 8'($urandom_range(0, 255));
      1: return 8'("a" + $urandom_range(0, 3));
      default: return 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 2));
    endcase
  endfunction

  // Send a well-formed pair, with occasional odd items mixed in.
  task automatic send_pair(input int unsigned l1, input int unsigned l2, input bit noise);
    int unsigned alpha;
    logic [7:0] s1 [$];
    int unsigned k;
    alpha = $urandom_range(0, 2);
    for (int i = 0; i < l1; i++) s1.push_back(rand_char(alpha));
    for (int i = 0; i < l1; i++) begin
      send_item(mk(0, s1[i], 1, i == l1 - 1, !(noise && $urandom_range(0, 30) == 0)));
      idle_gap();
    end
    if (l1 == 0) send_item(mk(0, 8'($urandom), 0, 1, 1'b1));
    if (noise && $urandom_range(0, 2) == 0)
      send_item(mk(0, 8'($urandom), 1'($urandom), 1'($urandom), 1));
    // seed the second string with the first sometimes so matches happen
    k = (l1 <= l2 && $urandom_range(0, 1)) ? $urandom_range(0, l2 - l1) : MAX_LEN + 1;
    for (int j = 0; j < l2; j++) begin
      send_item(mk(1, (j >= k && j < k + l1) ? s1[j-k] : rand_char(alpha), 1,
                    j == l2 - 1, !(noise && $urandom_range(0, 30) == 0)));
      idle_gap();
    end
    if (l2 == 0) send_item(mk(1, 8'($urandom), 0, 1, 1'b1));
  endtask

  typedef struct {
    in_item_t  it;
    bit        chk;
    out_item_t want;
  } row_t;

  initial begin
    row_t      dir_rows [$];
    pm_mode = COMPARE_MODE_RST;
    pm_limit = '0;
    pm_len1 = 0;
    pm_len2 = 0;
    pm_first_closed = 0;
    pm_missing = 0;
    pm_ovf = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table in reset mode (equality)
    dir_rows.push_back('{mk(0, 8'h00, 0, 1, 1), 0, '0});
    dir_rows.push_back('{mk(1, 8'hFF, 0, 1, 1), 1, '{1'b1, 9'd0, 1'b0}});  // empty == empty
    dir_rows.push_back('{mk(0, 8'h00, 1, 1, 1), 0, '0});
    dir_rows.push_back('{mk(1, 8'h00, 1, 1, 1), 1, '{1'b1, 9'd0, 1'b0}});  // zero byte
    dir_rows.push_back('{mk(0, 8'hFF, 1, 1, 0), 0, '0});
    dir_rows.push_back('{mk(1, 8'hFF, 1, 1, 1), 1, '{1'b0, 9'd0, 1'b0}});  // missing term
    dir_rows.push_back('{mk(0, 8'h61, 1, 1, 1), 0, '0});
    dir_rows.push_back('{mk(0, 8'h62, 1, 1, 1), 0, '0});   // ignored after close
    dir_rows.push_back('{mk(1, 8'h41, 1, 1, 1), 1, '{1'b0, 9'd0, 1'b0}});  // no fold here
    dir_rows.push_back('{mk(1, 8'h7A, 1, 0, 1), 0, '0});   // second before first closes
    dir_rows.push_back('{mk(1, 8'h7A, 1, 1, 1), 0, '0});
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it);
      if (dir_rows[i].chk && verdict_q.size() != 0 &&
          verdict_q[$] != dir_rows[i].want) begin
        $error("table row %0d: predictor %p, table %p", i, verdict_q[$], dir_rows[i].want);
        n_errors++;
      end
      idle_gap();
    end
    drain();

    // overflow in the first string, checked by table
    write_reg(REG_COMPARE_MODE, 16'(MODE_EDIT));
    write_reg(REG_DISTANCE_LIMIT, 16'hFFFF);
    for (int i = 0; i <= MAX_LEN; i++) send_item(mk(0, 8'hC1, 1, i == MAX_LEN, 1));
    send_item(mk(1, 8'h00, 1, 1, 1));
    if (verdict_q[$] != '{1'b0, 9'd0, 1'b1}) begin
      $error("overflow row: predictor %p", verdict_q[$]);
      n_errors++;
    end
    // overflow in the second string, items back to back
    send_item(mk(0, 8'h41, 1, 1, 1));
    for (int i = 0; i <= MAX_LEN; i++) send_item(mk(1, 8'h41, 1, i == MAX_LEN, 1));
    if (verdict_q[$] != '{1'b0, 9'd0, 1'b1}) begin
      $error("second overflow row: predictor %p", verdict_q[$]);
      n_errors++;
    end
    // full-length strings, folding and non-ASCII bytes
    send_pair(MAX_LEN, MAX_LEN, 0);
    send_pair(3, 3, 0);
    drain();
    write_reg(REG_COMPARE_MODE, 16'(MODE_RSVD));   // unknown mode answers false
    send_pair(2, 2, 0);
    drain();

    // random phases over all settings
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(REG_COMPARE_MODE, ph == 5 ? 16'(MODE_RSVD) : 16'($urandom_range(0, 2)));
      write_reg(REG_DISTANCE_LIMIT, ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF :
                16'($urandom_range(0, 6)));
      for (int p = 0; p < 5; p++) begin
        send_pair($urandom_range(0, 5), $urandom_range(0, 9), $urandom_range(0, 3) == 0);
        if (p == 2) drain();
      end
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
